FILE: rtl/bfc_pkg.sv
// shared types, codes and constants of the box filling controller
`default_nettype none

package bfc_pkg;

  // request kinds on the input channel
  typedef enum logic [1:0] {
    REQ_PRODUCT  = 2'd0,
    REQ_ESTOP    = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_HANDLING = 2'd3
  } req_e;

  // event codes reported with each result beat
  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_BOX_DONE     = 3'd1,
    EV_QUEUE_FULL   = 3'd2,
    EV_NO_BOX       = 3'd3,
    EV_STARVATION   = 3'd4,
    EV_DEFECT_LIMIT = 3'd5,
    EV_EMERGENCY    = 3'd6,
    EV_END          = 3'd7
  } event_e;

  // printer request codes
  typedef enum logic [1:0] {
    PRINT_NONE  = 2'd0,
    PRINT_BOX   = 2'd1,
    PRINT_FINAL = 2'd2
  } print_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_PRODUCTS_PER_BOX = 3'd0,
    CFG_MAX_DEFECTS      = 3'd1,
    CFG_BOXES_PER_BATCH  = 3'd2,
    CFG_STARVATION_TICKS = 3'd3,
    CFG_BATCH_NUMBER     = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned GoodW     = 10;
  localparam int unsigned DefW      = 8;
  localparam int unsigned WordW     = 16;

  localparam logic [GoodW-1:0] PpbReset   = 10'd10;
  localparam logic [DefW-1:0]  MaxDefReset = 8'd5;
  localparam logic [WordW-1:0] StarveReset = 16'd1000;
  localparam logic [GoodW-1:0] GoodMax    = '1;
  localparam logic [WordW-1:0] BadMax     = '1;

  // depth of the result queue, at least two
  localparam int unsigned ResDepth = 4;

  // one result record
  typedef struct packed {
    event_e           ev;
    logic [WordW-1:0] box;
    logic [GoodW-1:0] good;
    logic [WordW-1:0] bad;
    logic [WordW-1:0] batch;
    logic             inlet;
    logic             reject;
    print_e           print;
    logic             hw;
    logic             last;
  } rec_t;

  function automatic rec_t make_rec(input event_e ev, input logic [WordW-1:0] box,
                                    input logic [GoodW-1:0] good,
                                    input logic [WordW-1:0] bad, input print_e print,
                                    input logic hw);
    rec_t r;
    r        = '0;
    r.ev     = ev;
    r.box    = box;
    r.good   = good;
    r.bad    = bad;
    r.print  = print;
    r.hw     = hw;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/box_filling_controller_core.sv
// box filling controller: event handling, counters, valves and result queue
`default_nettype none

// results of an accepted beat are written into the result queue and leave from its head
// throughput: one input beat per cycle; each beat yields one or two result beats,
//   the result queue (four entries by default) stalls input while fewer than two slots are free
// output drains one result beat per cycle while out_stall_i is low, so two-result beats fill the queue
// reset: asynchronous active low; configuration returns to defaults, counters,
//   valves and flags clear, queue empties

module box_filling_controller_core
  import bfc_pkg::*;
#(
  parameter int unsigned Depth = ResDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // input beat channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic               is_defective_i,
  input  wire logic               box_present_i,
  input  wire logic               print_room_i,
  input  wire logic               end_requested_i,
  // result beat channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              event_code_o,
  output logic [WordW-1:0]        current_box_o,
  output logic [GoodW-1:0]        good_count_o,
  output logic [WordW-1:0]        bad_count_o,
  output logic [WordW-1:0]        batch_out_o,
  output logic                    inlet_valve_open_o,
  output logic                    reject_valve_open_o,
  output logic [1:0]              print_send_o,
  output logic                    handling_wanted_o,
  output logic                    last_result_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  // configuration registers
  logic [GoodW-1:0] ppb_q;
  logic [DefW-1:0]  max_def_q;
  logic [WordW-1:0] bpb_q;
  logic [WordW-1:0] starve_ticks_q;
  logic [WordW-1:0] batch_q;

  // controller state
  logic             filling_q, filling_d;
  logic [WordW-1:0] box_q, box_d;
  logic [GoodW-1:0] good_q, good_d;
  logic [WordW-1:0] bad_q, bad_d;
  logic [DefW-1:0]  phase_q, phase_d;
  logic [WordW-1:0] finished_q, finished_d;
  logic [WordW-1:0] timer_q, timer_d;
  logic             armed_q, armed_d;
  logic             inlet_q, inlet_d;
  logic             reject_q, reject_d;
  logic             ended_q, ended_d;

  // result records of the current beat
  rec_t rec0, rec1;
  logic two_res;
  logic box_done;
  logic hold_err;
  logic stop;
  rec_t tail_rec;
  logic tail_valid;

  // result queue
  rec_t            q_mem [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push = in_valid_i && !in_stall_o;
  assign pop  = out_valid_o && !out_stall_i;

  // room for the worst case of two result beats
  assign in_stall_o  = (cnt_q > CntW'(Depth - 2));
  assign out_valid_o = (cnt_q != '0);

  // ---------------------------------------------------------------------------
  // next state and result records for one input beat
  // ---------------------------------------------------------------------------
  always_comb begin
    filling_d  = filling_q;
    box_d      = box_q;
    good_d     = good_q;
    bad_d      = bad_q;
    phase_d    = phase_q;
    finished_d = finished_q;
    timer_d    = timer_q;
    armed_d    = armed_q;
    inlet_d    = inlet_q;
    reject_d   = reject_q;
    ended_d    = ended_q;
    rec0       = '0;
    rec1       = '0;
    two_res    = 1'b0;
    box_done   = 1'b0;
    hold_err   = 1'b0;
    stop       = 1'b0;
    tail_rec   = '0;
    tail_valid = 1'b0;

    unique case (req_e'(req_type_i))
      REQ_PRODUCT: begin
        // a product restarts the starvation watch unless the run is over
        if (!ended_q) begin
          armed_d = 1'b1;
          timer_d = '0;
        end
        if (!is_defective_i) begin
          reject_d = 1'b0;
          if (good_q != GoodMax) begin
            good_d = good_q + 1'b1;
          end
          if (good_d == ppb_q) begin
            stop = 1'b1;
          end
          rec0 = make_rec(EV_NONE, box_q, good_d, bad_q, PRINT_NONE, stop);
        end else begin
          reject_d = 1'b1;
          if (bad_q != BadMax) begin
            bad_d = bad_q + 1'b1;
          end
          // phase wraps at 256 and resets when it hits the limit
          phase_d = phase_q + 1'b1;
          if (phase_d == max_def_q) begin
            phase_d = '0;
            stop    = 1'b1;
          end
          rec0 = make_rec(stop ? EV_DEFECT_LIMIT : EV_NONE, box_q, good_q, bad_d,
                          PRINT_NONE, 1'b0);
        end
      end
      REQ_ESTOP: begin
        stop = 1'b1;
        rec0 = make_rec(EV_EMERGENCY, box_q, good_q, bad_q, PRINT_NONE, 1'b0);
      end
      REQ_TICK: begin
        if (armed_q) begin
          timer_d = timer_q + 1'b1;
          if (timer_d == starve_ticks_q) begin
            stop = 1'b1;
          end
        end
        rec0 = make_rec(stop ? EV_STARVATION : EV_NONE, box_q, good_q, bad_q,
                        PRINT_NONE, 1'b0);
      end
      REQ_HANDLING: begin
        rec0 = make_rec(EV_NONE, box_q, good_q, bad_q, PRINT_NONE, 1'b0);
        if (!ended_q && !filling_q) begin
          if (good_q >= ppb_q) begin
            if (print_room_i) begin
              // record carries the box before it is cleared
              rec0       = make_rec(EV_BOX_DONE, box_q, good_q, bad_q, PRINT_BOX, 1'b0);
              box_done   = 1'b1;
              finished_d = finished_q + 1'b1;
              box_d      = box_q + 1'b1;
              good_d     = '0;
              bad_d      = '0;
              phase_d    = '0;
            end else begin
              rec0     = make_rec(EV_QUEUE_FULL, box_q, good_q, bad_q, PRINT_NONE, 1'b0);
              hold_err = 1'b1;
            end
          end
          if (!hold_err) begin
            if (end_requested_i) begin
              ended_d    = 1'b1;
              armed_d    = 1'b0;
              timer_d    = '0;
              tail_rec   = make_rec(EV_END, box_d, good_d, bad_d, PRINT_FINAL, 1'b0);
              tail_valid = 1'b1;
            end else if (finished_d < bpb_q) begin
              if (box_present_i) begin
                filling_d = 1'b1;
                armed_d   = 1'b1;
                timer_d   = '0;
                inlet_d   = 1'b1;
              end else begin
                tail_rec   = make_rec(EV_NO_BOX, box_d, good_d, bad_d, PRINT_NONE, 1'b0);
                tail_valid = 1'b1;
              end
            end
          end
          // end or no-box follows a box-done record, else it is the only one
          if (tail_valid) begin
            if (box_done) begin
              rec1    = tail_rec;
              two_res = 1'b1;
            end else begin
              rec0 = tail_rec;
            end
          end
        end
      end
      default: ;
    endcase

    // closing the inlet also disarms the starvation watch
    if (stop) begin
      inlet_d   = 1'b0;
      armed_d   = 1'b0;
      timer_d   = '0;
      filling_d = 1'b0;
    end

    // valve drives after the whole step, batch id and last marks
    rec0.inlet  = inlet_d;
    rec0.reject = reject_d;
    rec0.batch  = batch_q;
    rec0.last   = !two_res;
    rec1.inlet  = inlet_d;
    rec1.reject = reject_d;
    rec1.batch  = batch_q;
    rec1.last   = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // configuration and controller state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppb_q          <= PpbReset;
      max_def_q      <= MaxDefReset;
      bpb_q          <= '0;
      starve_ticks_q <= StarveReset;
      batch_q        <= '0;
      filling_q      <= 1'b0;
      box_q          <= '0;
      good_q         <= '0;
      bad_q          <= '0;
      phase_q        <= '0;
      finished_q     <= '0;
      timer_q        <= '0;
      armed_q        <= 1'b0;
      inlet_q        <= 1'b0;
      reject_q       <= 1'b0;
      ended_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_PRODUCTS_PER_BOX: ppb_q          <= cfg_data_i[GoodW-1:0];
          CFG_MAX_DEFECTS:      max_def_q      <= cfg_data_i[DefW-1:0];
          CFG_BOXES_PER_BATCH:  bpb_q          <= cfg_data_i;
          CFG_STARVATION_TICKS: starve_ticks_q <= cfg_data_i;
          CFG_BATCH_NUMBER:     batch_q        <= cfg_data_i;
          default: ;
        endcase
      end
      if (push) begin
        filling_q  <= filling_d;
        box_q      <= box_d;
        good_q     <= good_d;
        bad_q      <= bad_d;
        phase_q    <= phase_d;
        finished_q <= finished_d;
        timer_q    <= timer_d;
        armed_q    <= armed_d;
        inlet_q    <= inlet_d;
        reject_q   <= reject_d;
        ended_q    <= ended_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result queue: one or two writes per input beat, one read per output beat
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= two_res ? PtrW'(wr_q + 2'd2) : PtrW'(wr_q + 1'b1);
      end
      if (pop) begin
        rd_q <= PtrW'(rd_q + 1'b1);
      end
      cnt_q <= CntW'(cnt_q + (push ? (two_res ? CntW'(2) : CntW'(1)) : CntW'(0))
                     - (pop ? CntW'(1) : CntW'(0)));
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= rec0;
      if (two_res) begin
        q_mem[PtrW'(wr_q + 1'b1)] <= rec1;
      end
    end
  end

  // output fields from the queue head
  assign event_code_o        = q_mem[rd_q].ev;
  assign current_box_o       = q_mem[rd_q].box;
  assign good_count_o        = q_mem[rd_q].good;
  assign bad_count_o         = q_mem[rd_q].bad;
  assign batch_out_o         = q_mem[rd_q].batch;
  assign inlet_valve_open_o  = q_mem[rd_q].inlet;
  assign reject_valve_open_o = q_mem[rd_q].reject;
  assign print_send_o        = q_mem[rd_q].print;
  assign handling_wanted_o   = q_mem[rd_q].hw;
  assign last_result_o       = q_mem[rd_q].last;

endmodule

`default_nettype wire
